[rtl/assert_macros.svh]
// assertion macros for the echo delay core
// every macro samples on clk and is disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfed_pkg.sv]
// shared types, constants, microcode table and saturation helper for the echo delay core
// no dependencies
package sfed_pkg;

  localparam int ADDR_BITS   = 17;
  localparam int DELAY_DEPTH = 1 << ADDR_BITS;
  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_W     = 17;
  localparam int GAIN_W      = 16;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int FILL_W      = ADDR_BITS + 1;
  localparam int STEP_W      = 3;
  localparam int FRAC_BITS   = 15;
  localparam int UNITY_Q15   = 1 << FRAC_BITS;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [STEP_W-1:0]             step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY,
    REG_FEEDBACK,
    REG_WET_LEFT,
    REG_WET_RIGHT,
    REG_DRY
  } cfg_reg_t;

  typedef enum logic [2:0] {
    A_RD_L,
    A_RD_R,
    A_WET_L,
    A_WET_R,
    A_IN_L,
    A_IN_R
  } op_a_t;

  typedef enum logic [1:0] {
    G_WET_L,
    G_WET_R,
    G_FEEDBACK,
    G_DRY
  } op_g_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_WET_L,
    DST_WET_R,
    DST_FBK_L,
    DST_FBK_R,
    DST_DRY_L,
    DST_DRY_R
  } dst_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t next;
    op_a_t a;
    op_g_t g;
    dst_t  dst;
    logic  in_ld;
    logic  mem_rd;
    logic  mem_wr;
    logic  out_ld;
  } uword_t;

  typedef struct packed {
    logic  in_ld;
    logic  mem_rd;
    logic  mem_wr;
    logic  out_ld;
    op_a_t a;
    op_g_t g;
    dst_t  dst;
  } ctl_t;

  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_t;

  // one frame: read, six products through the shared multiplier (write back alongside the fifth), output
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '{cond: COND_ALWAYS, next: step + 1'b1, a: A_RD_L, g: G_WET_L, dst: DST_NONE,
          in_ld: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0, out_ld: 1'b0};
    case (step)
      3'd0: begin
        w.cond   = COND_IN;
        w.in_ld  = 1'b1;
        w.mem_rd = 1'b1;
      end
      3'd1: begin
        w.a   = A_RD_L;
        w.g   = G_WET_L;
        w.dst = DST_WET_L;
      end
      3'd2: begin
        w.a   = A_RD_R;
        w.g   = G_WET_R;
        w.dst = DST_WET_R;
      end
      3'd3: begin
        w.a   = A_WET_L;
        w.g   = G_FEEDBACK;
        w.dst = DST_FBK_L;
      end
      3'd4: begin
        w.a   = A_WET_R;
        w.g   = G_FEEDBACK;
        w.dst = DST_FBK_R;
      end
      3'd5: begin
        w.a      = A_IN_L;
        w.g      = G_DRY;
        w.dst    = DST_DRY_L;
        w.mem_wr = 1'b1;
      end
      3'd6: begin
        w.a   = A_IN_R;
        w.g   = G_DRY;
        w.dst = DST_DRY_R;
      end
      3'd7: begin
        w.cond   = COND_OUT;
        w.out_ld = 1'b1;
        w.next   = '0;
      end
      default: begin
        w.next = '0;
      end
    endcase
    return w;
  endfunction

  function automatic sample_t sat_add(input sample_t x, input sample_t y);
    logic signed [SAMPLE_BITS:0] s;
    sample_t r;
    s = {x[SAMPLE_BITS-1], x} + {y[SAMPLE_BITS-1], y};
    if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
      r = s[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      r = s[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/sfed_ram.sv]
// simple dual-port ram, one write and one registered read port
// no dependencies
module sfed_ram #(
  parameter int ADDR_W = 17,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sfed_sequencer.sv]
// microcode sequencer: step counter, control rom lookup, jump conditions, output valid
// depends on sfed_pkg
module sfed_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  output logic          in_ready,
  output logic          out_valid,
  output sfed_pkg::ctl_t ctl
);
  import sfed_pkg::*;

  step_t  step;
  step_t  step_next;
  logic   out_valid_next;
  uword_t uw;
  logic   fire;

  assign uw = ucode(step);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS: fire = 1'b1;
      COND_IN:     fire = in_valid;
      COND_OUT:    fire = !out_valid || out_ready;
      default:     fire = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_next = fire ? uw.next : step;
  end

  // control outputs
  always_comb begin
    in_ready   = (uw.cond == COND_IN);
    ctl.in_ld  = fire && uw.in_ld;
    ctl.mem_rd = fire && uw.mem_rd;
    ctl.mem_wr = fire && uw.mem_wr;
    ctl.out_ld = fire && uw.out_ld;
    ctl.a      = uw.a;
    ctl.g      = uw.g;
    ctl.dst    = fire ? uw.dst : DST_NONE;
  end

  always_comb begin
    if (ctl.out_ld) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/sfed_datapath.sv]
// datapath: config registers, delay stores, shared q1.15 multiplier, saturating adders
// depends on sfed_pkg and sfed_ram
module sfed_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sfed_pkg::cfg_t   cfg,
  input  sfed_pkg::ctl_t   ctl,
  input  sfed_pkg::sample_t left_in,
  input  sfed_pkg::sample_t right_in,
  output sfed_pkg::sample_t left_out,
  output sfed_pkg::sample_t right_out
);
  import sfed_pkg::*;

  localparam int EXT_W  = (ADDR_BITS > DELAY_W) ? ADDR_BITS : DELAY_W;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

  logic [DELAY_W-1:0] delay_samples;
  gain_t              feedback_gain;
  gain_t              wet_gain_left;
  gain_t              wet_gain_right;
  gain_t              dry_gain;
  gain_t              gain_wr;

  logic [ADDR_BITS-1:0] wp;
  logic [FILL_W-1:0]    fill;
  logic [EXT_W-1:0]     delay_ext;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 rd_ok;

  logic [2*SAMPLE_BITS-1:0] ram_q;
  logic [2*SAMPLE_BITS-1:0] ram_d;

  sample_t in_l, in_r;
  sample_t rd_l, rd_r;
  sample_t wet_l, wet_r, fbk_l, fbk_r, dry_l, dry_r;

  sample_t                    mul_a;
  gain_t                      mul_g;
  logic signed [GAIN_W:0]     mul_g_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   rnd;
  sample_t                    mul_res;

  // gains above unity clamp to unity
  always_comb begin
    if (cfg.data[GAIN_W-1:0] > GAIN_W'(UNITY_Q15)) begin
      gain_wr = GAIN_W'(UNITY_Q15);
    end else begin
      gain_wr = cfg.data[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples  <= DELAY_W'(22050);
      feedback_gain  <= GAIN_W'(23170);
      wet_gain_left  <= GAIN_W'(23170);
      wet_gain_right <= GAIN_W'(23170);
      dry_gain       <= GAIN_W'(23170);
    end else if (cfg.write) begin
      case (cfg.index)
        REG_DELAY:     delay_samples  <= cfg.data[DELAY_W-1:0];
        REG_FEEDBACK:  feedback_gain  <= gain_wr;
        REG_WET_LEFT:  wet_gain_left  <= gain_wr;
        REG_WET_RIGHT: wet_gain_right <= gain_wr;
        REG_DRY:       dry_gain       <= gain_wr;
        default:       ;
      endcase
    end
  end

  // read address wraps modulo the store depth
  assign delay_ext = EXT_W'(delay_samples);
  assign rd_addr   = wp - delay_ext[ADDR_BITS-1:0];

  assign ram_d = {sat_add(in_r, fbk_r), sat_add(in_l, fbk_l)};

  sfed_ram #(
    .ADDR_W(ADDR_BITS),
    .DATA_W(2 * SAMPLE_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.mem_wr),
    .waddr(wp),
    .wdata(ram_d),
    .re   (ctl.mem_rd),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // entries at or beyond the fill count were never written and read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctl.mem_wr) begin
      wp <= wp + 1'b1;
      if (fill != FILL_W'(DELAY_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      rd_ok <= ({1'b0, rd_addr} < fill);
    end
    if (ctl.in_ld) begin
      in_l <= left_in;
      in_r <= right_in;
    end
  end

  assign rd_l = rd_ok ? ram_q[SAMPLE_BITS-1:0] : '0;
  assign rd_r = rd_ok ? ram_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;

  always_comb begin
    case (ctl.a)
      A_RD_L:  mul_a = rd_l;
      A_RD_R:  mul_a = rd_r;
      A_WET_L: mul_a = wet_l;
      A_WET_R: mul_a = wet_r;
      A_IN_L:  mul_a = in_l;
      A_IN_R:  mul_a = in_r;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.g)
      G_WET_L:    mul_g = wet_gain_left;
      G_WET_R:    mul_g = wet_gain_right;
      G_FEEDBACK: mul_g = feedback_gain;
      G_DRY:      mul_g = dry_gain;
      default:    mul_g = '0;
    endcase
  end

  // round half up, then arithmetic shift by the fraction bits
  assign mul_g_s = {1'b0, mul_g};
  assign prod    = mul_a * mul_g_s;
  assign rnd     = prod + PROD_W'(ROUND_HALF);
  assign mul_res = rnd[FRAC_BITS +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    case (ctl.dst)
      DST_WET_L: wet_l <= mul_res;
      DST_WET_R: wet_r <= mul_res;
      DST_FBK_L: fbk_l <= mul_res;
      DST_FBK_R: fbk_r <= mul_res;
      DST_DRY_L: dry_l <= mul_res;
      DST_DRY_R: dry_r <= mul_res;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      left_out  <= sat_add(wet_l, dry_l);
      right_out <= sat_add(wet_r, dry_r);
    end
  end

endmodule

[rtl/stereo_feedback_echo_delay_core.sv]
// top level of the stereo feedback echo delay: sequencer plus datapath
// depends on sfed_pkg, sfed_sequencer, sfed_datapath and assert_macros.svh
//
//   channel  handshake             payload
//   cfg      cfg_write             cfg_index, cfg_data
//   in       in_valid / in_ready   left_in, right_in
//   out      out_valid / out_ready left_out, right_out
//
// one stereo frame runs through steps 0 to 7 of a microprogram that runs six products in turn
// through one shared 24x17 multiplier; the result loads in step 7, after the input beat in step 0
// a new input beat is taken in step 0 while the previous result waits in the output register
// if that result is still not taken by step 7, the sequencer holds there
// no clearing pass after reset: a fill count marks store entries not yet written as zero
`include "assert_macros.svh"

module stereo_feedback_echo_delay_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sfed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfed_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sfed_pkg::sample_t                left_in,
  input  sfed_pkg::sample_t                right_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sfed_pkg::sample_t                left_out,
  output sfed_pkg::sample_t                right_out
);
  import sfed_pkg::*;

  cfg_t cfg;
  ctl_t ctl;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sfed_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .ctl      (ctl)
  );

  sfed_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ctl      (ctl),
    .left_in  (left_in),
    .right_in (right_in),
    .left_out (left_out),
    .right_out(right_out)
  );

  `SFED_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after input beat")
  `SFED_ASSERT_NOW(a_load_only_on_beat, ctl.in_ld, in_valid && in_ready, "input load without beat")
  `SFED_ASSERT_NOW(a_no_overwrite, ctl.out_ld, !out_valid || out_ready, "pending result overwritten")
  `SFED_ASSERT_NEXT(a_valid_after_load, ctl.out_ld, out_valid, "output load without valid")

endmodule
